### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers shared by the transform RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/dct4_pkg.sv
// ---------------------------------------------------------------------------
// dct4_pkg
// Constants, coefficient rounding and pipeline types for the 8-point DCT-IV.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dct4_pkg;

  localparam int OUT_W              = 20;
  localparam int DEF_SAMPLE_WIDTH   = 16;
  localparam int DEF_COEF_FRAC_BITS = 17;

  // coefficients as 32-bit unsigned fractions
  localparam logic [31:0] C32_R2 = 32'hB504F300;  // sqrt(1/2)
  localparam logic [31:0] C32_C8 = 32'hEC835E00;  // cos pi/8
  localparam logic [31:0] C32_S8 = 32'h61F78A80;  // sin pi/8
  localparam logic [31:0] C32_C1 = 32'hFEC46D00;
  localparam logic [31:0] C32_S1 = 32'h1917A6C0;
  localparam logic [31:0] C32_C3 = 32'hF4FA0B00;
  localparam logic [31:0] C32_S3 = 32'h4A501880;
  localparam logic [31:0] C32_C5 = 32'hE1C59800;
  localparam logic [31:0] C32_S5 = 32'h78AD7500;
  localparam logic [31:0] C32_C7 = 32'hC5E40300;
  localparam logic [31:0] C32_S7 = 32'hA2679900;

  // pipeline register stages
  localparam int NUM_STAGES    = 7;
  localparam int STG_ROT_MUL   = 0;
  localparam int STG_ROT_SUM   = 1;
  localparam int STG_BFLY      = 2;
  localparam int STG_MID       = 3;
  localparam int STG_SCALE_IN  = 4;
  localparam int STG_SCALE_MUL = 5;
  localparam int STG_OUT       = 6;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // round a 32-bit fraction to nearest, half up, at frac fractional bits
  function automatic int coef_q(input logic [31:0] c32, input int frac);
    logic [32:0] s;
    s = {1'b0, c32} + (33'd1 << (31 - frac));
    return int'(s >> (32 - frac));
  endfunction

endpackage

`default_nettype wire

### design/dct4_8_point_transform.sv
// ---------------------------------------------------------------------------
// dct4_8_point_transform
// Unnormalized 8-point DCT-IV of eight signed samples, fixed-point
// coefficients, round to nearest, 20-bit saturated coefficients out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one beat of eight samples
//   in_0..in_7; output channel out_valid/out_ready carries one beat of
//   eight coefficients out_0..out_7.
//   Throughput is one beat per cycle while out_ready stays high: seven
//   register stages, each with its own valid bit, with four stage-one
//   rotation lanes working side by side and a merge block with two pi/8
//   rotation lanes and the scale.
//   When the receiver stalls, the output holds and stages behind it keep
//   advancing into empty slots; in_ready drops only once every stage is
//   full. in_ready is high whenever out_ready is high.
//   Reset clears all valid bits; no results are pending afterwards.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dct4_8_point_transform #(
  parameter int SAMPLE_WIDTH   = dct4_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = dct4_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_0,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_1,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_2,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_3,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_4,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_5,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_6,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_7,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dct4_pkg::OUT_W-1:0] out_0,
  output logic signed [dct4_pkg::OUT_W-1:0] out_1,
  output logic signed [dct4_pkg::OUT_W-1:0] out_2,
  output logic signed [dct4_pkg::OUT_W-1:0] out_3,
  output logic signed [dct4_pkg::OUT_W-1:0] out_4,
  output logic signed [dct4_pkg::OUT_W-1:0] out_5,
  output logic signed [dct4_pkg::OUT_W-1:0] out_6,
  output logic signed [dct4_pkg::OUT_W-1:0] out_7
);

  import dct4_pkg::*;

  localparam int F    = COEF_FRAC_BITS;
  localparam int W1   = SAMPLE_WIDTH + 2;
  localparam int K_C1 = coef_q(C32_C1, F);
  localparam int K_S1 = coef_q(C32_S1, F);
  localparam int K_C3 = coef_q(C32_C3, F);
  localparam int K_S3 = coef_q(C32_S3, F);
  localparam int K_C5 = coef_q(C32_C5, F);
  localparam int K_S5 = coef_q(C32_S5, F);
  localparam int K_C7 = coef_q(C32_C7, F);
  localparam int K_S7 = coef_q(C32_S7, F);

  stage_en_t en;
  logic [NUM_STAGES-1:0] vld;

  logic signed [W1-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  // a stage loads when it is empty or the one after it moves
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NUM_STAGES-1];

  // stage one: mirrored-pair rotation lanes
  dct4_rot #(
    .AW(SAMPLE_WIDTH), .OW(W1), .F(F),
    .KXA(K_C1), .KXB(K_S1), .KYA(K_S1), .KYB(-K_C1)
  ) u_rot_a (
    .clk(clk), .en_mul(en[STG_ROT_MUL]), .en_sum(en[STG_ROT_SUM]),
    .a(in_0), .b(in_7), .x(ax), .y(ay)
  );

  dct4_rot #(
    .AW(SAMPLE_WIDTH), .OW(W1), .F(F),
    .KXA(K_C3), .KXB(K_S3), .KYA(-K_S3), .KYB(K_C3)
  ) u_rot_b (
    .clk(clk), .en_mul(en[STG_ROT_MUL]), .en_sum(en[STG_ROT_SUM]),
    .a(in_1), .b(in_6), .x(bx), .y(by)
  );

  dct4_rot #(
    .AW(SAMPLE_WIDTH), .OW(W1), .F(F),
    .KXA(K_C5), .KXB(K_S5), .KYA(K_S5), .KYB(-K_C5)
  ) u_rot_c (
    .clk(clk), .en_mul(en[STG_ROT_MUL]), .en_sum(en[STG_ROT_SUM]),
    .a(in_2), .b(in_5), .x(cx), .y(cy)
  );

  dct4_rot #(
    .AW(SAMPLE_WIDTH), .OW(W1), .F(F),
    .KXA(K_C7), .KXB(K_S7), .KYA(-K_S7), .KYB(K_C7)
  ) u_rot_d (
    .clk(clk), .en_mul(en[STG_ROT_MUL]), .en_sum(en[STG_ROT_SUM]),
    .a(in_3), .b(in_4), .x(dx), .y(dy)
  );

  dct4_merge #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_merge (
    .clk(clk), .en(en),
    .ax(ax), .ay(ay), .bx(bx), .by(by),
    .cx(cx), .cy(cy), .dx(dx), .dy(dy),
    .out_0(out_0), .out_1(out_1), .out_2(out_2), .out_3(out_3),
    .out_4(out_4), .out_5(out_5), .out_6(out_6), .out_7(out_7)
  );

  `ASSERT_CLK(a_ready_when_drained, out_ready |-> in_ready, "in_ready low while out_ready high")
  `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "in_ready low with output empty")
  `ASSERT_CLK_ALWAYS(a_reset_clears, $past(rst) |-> !out_valid, "out_valid set after reset")

endmodule

`default_nettype wire

### design/dct4_rot.sv
// ---------------------------------------------------------------------------
// dct4_rot
// Rotation lane: two fixed-coefficient dot products, registered products,
// then one rounded sum per output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dct4_rot #(
  parameter int AW  = 16,
  parameter int OW  = 18,
  parameter int F   = 17,
  parameter int KXA = 0,
  parameter int KXB = 0,
  parameter int KYA = 0,
  parameter int KYB = 0
) (
  input  logic                 clk,
  input  logic                 en_mul,
  input  logic                 en_sum,
  input  logic signed [AW-1:0] a,
  input  logic signed [AW-1:0] b,
  output logic signed [OW-1:0] x,
  output logic signed [OW-1:0] y
);

  localparam int KW   = F + 2;
  localparam int PW   = AW + KW;
  localparam int SUMW = PW + 1;

  localparam logic signed [KW-1:0] KXA_S = KW'(KXA);
  localparam logic signed [KW-1:0] KXB_S = KW'(KXB);
  localparam logic signed [KW-1:0] KYA_S = KW'(KYA);
  localparam logic signed [KW-1:0] KYB_S = KW'(KYB);
  localparam logic signed [SUMW-1:0] HALF = {{(SUMW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

  logic signed [PW-1:0]   pxa, pxb, pya, pyb;
  logic signed [SUMW-1:0] sum_x, sum_y, rnd_x, rnd_y;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      pxa <= a * KXA_S;
      pxb <= b * KXB_S;
      pya <= a * KYA_S;
      pyb <= b * KYB_S;
    end
  end

  always_comb begin
    sum_x = SUMW'(pxa) + SUMW'(pxb) + HALF;
    sum_y = SUMW'(pya) + SUMW'(pyb) + HALF;
    rnd_x = sum_x >>> F;
    rnd_y = sum_y >>> F;
  end

  always_ff @(posedge clk) begin
    if (en_sum) begin
      x <= rnd_x[OW-1:0];
      y <= rnd_y[OW-1:0];
    end
  end

endmodule

`default_nettype wire

### design/dct4_merge.sv
// ---------------------------------------------------------------------------
// dct4_merge
// Combines the four stage-one lanes: sum/difference butterflies, pi/8
// rotations, output permutation, sqrt(1/2) scale and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dct4_merge #(
  parameter int SAMPLE_WIDTH   = dct4_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC_BITS = dct4_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  dct4_pkg::stage_en_t                  en,
  input  logic signed [SAMPLE_WIDTH+1:0]       ax,
  input  logic signed [SAMPLE_WIDTH+1:0]       ay,
  input  logic signed [SAMPLE_WIDTH+1:0]       bx,
  input  logic signed [SAMPLE_WIDTH+1:0]       by,
  input  logic signed [SAMPLE_WIDTH+1:0]       cx,
  input  logic signed [SAMPLE_WIDTH+1:0]       cy,
  input  logic signed [SAMPLE_WIDTH+1:0]       dx,
  input  logic signed [SAMPLE_WIDTH+1:0]       dy,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_0,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_1,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_2,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_3,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_4,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_5,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_6,
  output logic signed [dct4_pkg::OUT_W-1:0]    out_7
);

  import dct4_pkg::*;

  localparam int F    = COEF_FRAC_BITS;
  localparam int W1   = SAMPLE_WIDTH + 2;
  localparam int W2   = W1 + 1;
  localparam int W3   = W2 + 1;
  localparam int W4   = W3 + 1;
  localparam int KW   = F + 2;
  localparam int MW   = W4 + KW;
  localparam int RW   = MW + 1;
  localparam int XW   = ((W4 > OUT_W) ? W4 : OUT_W) + 1;

  localparam int K_R2 = coef_q(C32_R2, F);
  localparam int K_C8 = coef_q(C32_C8, F);
  localparam int K_S8 = coef_q(C32_S8, F);

  localparam logic signed [KW-1:0] K_R2_S = KW'(K_R2);
  localparam logic signed [RW-1:0] HALF   = {{(RW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [XW-1:0] SAT_MAX = {{(XW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_MIN = {{(XW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [XW-1:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[OUT_W-1:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

  logic signed [W2-1:0] p0, p1, q0, q1, r0, r1, t0, t1;
  logic signed [W3-1:0] sx, sy, ux, uy;
  logic signed [W3-1:0] tx, ty, vx, vy;
  logic signed [W3-1:0] sx4, ux4, sx5, ux5;
  logic signed [W4-1:0] e3, e4;
  logic signed [W4-1:0] d1, d2, d5, d6;
  logic signed [MW-1:0] m3, m4;
  logic signed [RW-1:0] rs3, rs4;
  logic signed [W4-1:0] r3, r4;

  // stage two: sums and differences
  always_ff @(posedge clk) begin
    if (en[STG_BFLY]) begin
      p0 <= W2'(ax) + W2'(dx);
      p1 <= W2'(ax) - W2'(dx);
      q0 <= W2'(bx) + W2'(cx);
      q1 <= W2'(bx) - W2'(cx);
      r0 <= W2'(dy) + W2'(ay);
      r1 <= W2'(dy) - W2'(ay);
      t0 <= W2'(cy) + W2'(by);
      t1 <= W2'(cy) - W2'(by);
    end
  end

  // stage three: plain butterflies
  always_ff @(posedge clk) begin
    if (en[STG_MID]) begin
      sx <= W3'(p0) + W3'(q0);
      sy <= W3'(p0) - W3'(q0);
      ux <= W3'(r0) + W3'(t0);
      uy <= W3'(r0) - W3'(t0);
    end
  end

  // stage three: pi/8 rotations
  dct4_rot #(
    .AW(W2), .OW(W3), .F(F),
    .KXA(K_C8), .KXB(K_S8), .KYA(K_S8), .KYB(-K_C8)
  ) u_rot_t (
    .clk(clk), .en_mul(en[STG_MID]), .en_sum(en[STG_SCALE_IN]),
    .a(p1), .b(q1), .x(tx), .y(ty)
  );

  dct4_rot #(
    .AW(W2), .OW(W3), .F(F),
    .KXA(K_C8), .KXB(K_S8), .KYA(K_S8), .KYB(-K_C8)
  ) u_rot_v (
    .clk(clk), .en_mul(en[STG_MID]), .en_sum(en[STG_SCALE_IN]),
    .a(r1), .b(t1), .x(vx), .y(vy)
  );

  always_ff @(posedge clk) begin
    if (en[STG_SCALE_IN]) begin
      e3  <= W4'(sy) + W4'(uy);
      e4  <= W4'(sy) - W4'(uy);
      sx4 <= sx;
      ux4 <= ux;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_SCALE_MUL]) begin
      d1  <= W4'(tx) - W4'(vy);
      d2  <= W4'(tx) + W4'(vy);
      d5  <= W4'(ty) - W4'(vx);
      d6  <= W4'(ty) + W4'(vx);
      m3  <= e3 * K_R2_S;
      m4  <= e4 * K_R2_S;
      sx5 <= sx4;
      ux5 <= ux4;
    end
  end

  always_comb begin
    rs3 = (RW'(m3) + HALF) >>> F;
    rs4 = (RW'(m4) + HALF) >>> F;
    r3  = rs3[W4-1:0];
    r4  = rs4[W4-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      out_0 <= sat(XW'(sx5));
      out_1 <= sat(XW'(d1));
      out_2 <= sat(XW'(d2));
      out_3 <= sat(XW'(r3));
      out_4 <= sat(XW'(r4));
      out_5 <= sat(XW'(d5));
      out_6 <= sat(XW'(d6));
      out_7 <= sat(XW'(ux5));
    end
  end

endmodule

`default_nettype wire
